FILE: rtl/core/sm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 package
// State encoding, constants and round helper functions for the SM3 core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a word
        ST_COMP,    // 64 compression rounds
        ST_PAD,     // push padding words
        ST_OUT      // emit 8 digest words
    } t_state;

    localparam logic [31:0] TJ_LOW   = 32'h79CC4519;
    localparam logic [31:0] TJ_HIGH  = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sm3_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 hash core
// Streams big-endian message words, pads, compresses and emits the digest.
// ----------------------------------------------------------------------------
// Input: a word that does not fill a block is accepted while idle. A word that
//   closes a block starts compression, one compression round per cycle.
// Last word: padding fills one or two blocks, each pushed word by word and
//   compressed, then 8 digest words, one per accepted output cycle.
// No new word is taken while a block is compressed, padding is pushed or the
//   digest is output: o_ready is high only in ST_IDLE.
// Reset: synchronous active low; IV loaded, counters cleared, no output.
module sm3_hash_core
    import sm3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_done
);

    t_state r_state, n_state;

    logic [31:0] r_cv [8];
    logic [31:0] r_rr [8];      // A..H
    logic [31:0] r_w  [16];     // sliding window of W[j..j+15]
    logic [3:0]  r_wib;         // words in block
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic [2:0]  r_oidx;
    logic        r_final;       // message closed, padding pending
    logic        r_lenw;        // pad stage: length words written
    logic        r_lenok;       // current pad block carries the length
    logic        r_padfirst;    // 0x80 word still owed (full last word)

    // ---- input decode ----
    logic [2:0]  nb;
    logic [31:0] keep, merged;
    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        unique case (nb)
            3'd0:    keep = 32'h0;
            3'd1:    keep = 32'hFF000000;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFFFFFF00;
            default: keep = 32'hFFFFFFFF;
        endcase
        merged = i_data_word & keep;
        // full last word: the 0x80 byte goes into the next word
        if (nb != 3'd4)
            merged = merged
                   | ({24'h0, PAD_BYTE} << ({3'b000, 2'd3 - nb[1:0]} * 5'd8));
    end

    // ---- padding word source ----
    logic [31:0] pad_word;
    always_comb begin
        priority if (r_padfirst)            pad_word = {PAD_BYTE, 24'h0};
        else if (r_lenok && r_wib == 4'd14) pad_word = r_bits[63:32];
        else if (r_lenok && r_wib == 4'd15) pad_word = r_bits[31:0];
        else                                pad_word = 32'h0;
    end

    // ---- one compression round (shared unit) ----
    logic [31:0] wj, wpj, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;
    always_comb begin
        wj   = r_w[0];
        wpj  = r_w[0] ^ r_w[4];
        tj   = (r_round < 6'd16) ? TJ_LOW : TJ_HIGH;
        a12  = rotl(r_rr[0], 5'd12);
        ss1  = rotl(a12 + r_rr[4] + rotl(tj, r_round[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (r_round < 6'd16) begin
            ff = r_rr[0] ^ r_rr[1] ^ r_rr[2];
            gg = r_rr[4] ^ r_rr[5] ^ r_rr[6];
        end else begin
            ff = (r_rr[0] & r_rr[1]) | (r_rr[0] & r_rr[2]) | (r_rr[1] & r_rr[2]);
            gg = (r_rr[4] & r_rr[5]) | (~r_rr[4] & r_rr[6]);
        end
        tt1  = ff + r_rr[3] + ss2 + wpj;
        tt2  = gg + r_rr[7] + ss1 + wj;
        // expansion: W[j+16]
        wnew = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
             ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    // push of a word into the block buffer (input or padding)
    logic push_in, push_pad, push, blk_full;
    logic [31:0] push_data;
    always_comb begin
        push_in   = i_valid && o_ready;
        push_pad  = (r_state == ST_PAD);
        push      = push_in || push_pad;
        push_data = push_pad ? pad_word : (i_last_word ? merged : i_data_word);
        blk_full  = push && (r_wib == 4'd15);
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (push_in) begin
                if (blk_full)         n_state = ST_COMP;
                else if (i_last_word) n_state = ST_PAD;
            end
            ST_COMP: if (r_round == 6'd63)
                n_state = r_final ? (r_lenw ? ST_OUT : ST_PAD) : ST_IDLE;
            ST_PAD:  if (blk_full) n_state = ST_COMP;
            ST_OUT:  if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- outputs ----
    always_comb begin
        o_ready       = (r_state == ST_IDLE);
        o_valid       = (r_state == ST_OUT);
        o_digest_word = r_cv[r_oidx];
        o_word_index  = r_oidx;
        o_digest_done = (r_oidx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wib      <= '0;
            r_bits     <= '0;
            r_round    <= '0;
            r_oidx     <= '0;
            r_final    <= 1'b0;
            r_lenw     <= 1'b0;
            r_lenok    <= 1'b0;
            r_padfirst <= 1'b0;
            for (int i = 0; i < 8; i++) r_cv[i] <= SM3_IV[255-32*i -: 32];
        end else begin
            r_state <= n_state;
            if (push) begin
                r_w[r_wib] <= push_data;
                r_wib      <= r_wib + 4'd1;
                if (push_pad) begin
                    r_padfirst <= 1'b0;
                    // end of a pad block: either the length went in, or the
                    // next block takes it
                    if (r_wib == 4'd15 && !r_padfirst) begin
                        if (r_lenok) r_lenw  <= 1'b1;
                        else         r_lenok <= 1'b1;
                    end
                end
            end
            if (push_in) begin
                if (i_last_word) begin
                    r_bits     <= r_bits + {58'h0, nb, 3'b000};
                    r_final    <= 1'b1;
                    r_padfirst <= (nb == 3'd4);
                    // no room for the length when the 0x80 byte lands in slot 14
                    r_lenok    <= (nb == 3'd4) ? (r_wib != 4'd13) : (r_wib != 4'd14);
                end else begin
                    r_bits <= r_bits + 64'd32;
                end
            end
            if (blk_full) begin
                r_round <= '0;
                for (int i = 0; i < 8; i++) r_rr[i] <= r_cv[i];
            end
            if (r_state == ST_COMP) begin
                r_rr[0] <= tt1;
                r_rr[1] <= r_rr[0];
                r_rr[2] <= rotl(r_rr[1], 5'd9);
                r_rr[3] <= r_rr[2];
                r_rr[4] <= perm0(tt2);
                r_rr[5] <= r_rr[4];
                r_rr[6] <= rotl(r_rr[5], 5'd19);
                r_rr[7] <= r_rr[6];
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wnew;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_cv[0] <= r_cv[0] ^ tt1;
                    r_cv[1] <= r_cv[1] ^ r_rr[0];
                    r_cv[2] <= r_cv[2] ^ rotl(r_rr[1], 5'd9);
                    r_cv[3] <= r_cv[3] ^ r_rr[2];
                    r_cv[4] <= r_cv[4] ^ perm0(tt2);
                    r_cv[5] <= r_cv[5] ^ r_rr[4];
                    r_cv[6] <= r_cv[6] ^ rotl(r_rr[5], 5'd19);
                    r_cv[7] <= r_cv[7] ^ r_rr[6];
                end
            end
            if (r_state == ST_OUT && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_bits     <= '0;
                    r_wib      <= '0;
                    r_final    <= 1'b0;
                    r_lenw     <= 1'b0;
                    r_lenok    <= 1'b0;
                    r_padfirst <= 1'b0;
                    for (int i = 0; i < 8; i++) r_cv[i] <= SM3_IV[255-32*i -: 32];
                end
            end
        end
    end

    // ---- assertions ----
    a_round_only_in_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_COMP) |=> (r_round == 6'd0) || (r_state == ST_COMP))
        else $error("round counter moved outside compression");
    a_comp_starts_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_COMP) ##1 (r_state == ST_COMP) |-> (r_wib == 4'd0))
        else $error("compression started without a full block");
    a_out_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_final && r_lenw)
        else $error("digest emitted before padding completed");
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_done) |=> (r_state == ST_IDLE) && !r_final)
        else $error("state not cleared after digest");

endmodule
`default_nettype wire
